@@ rtl/tofwh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tofwh_pkg
// Shared types and constants of the time of flight / wavelength histogram.
// ----------------------------------------------------------------------------
package tofwh_pkg;

   localparam int CsrAddrWidth = 5;

   localparam logic [2:0] REG_BINS_TOF  = 3'd0;
   localparam logic [2:0] REG_BINS_WAVE = 3'd1;
   localparam logic [2:0] REG_TOF_LOW   = 3'd2;
   localparam logic [2:0] REG_TOF_HIGH  = 3'd3;
   localparam logic [2:0] REG_WAVE_LOW  = 3'd4;
   localparam logic [2:0] REG_WAVE_HIGH = 3'd5;
   localparam logic [2:0] REG_USE_WT    = 3'd6;
   localparam logic [2:0] REG_EXCLUSIVE = 3'd7;

   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] DIV_STEPS_LAST = 3'd6;

   typedef struct packed {
      logic [6:0]  bins_tof;
      logic [6:0]  bins_wave;
      logic [31:0] tof_low;
      logic [31:0] tof_high;
      logic [23:0] wave_low;
      logic [23:0] wave_high;
      logic        use_weight;
      logic        exclusive;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic div_step;
      logic mem_rd;
      logic update;
      logic clr_wr;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic clr_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/tof_wavelength_histogram_2d.sv @@
// Each accepted word passes one load step, a 7-step restoring divider on
// each axis (one quotient bit per cycle on both axes), one memory read step
// and one update step, which waits while the output is held. A new word is
// taken only after the previous one has left the update step.
// Reset: synchronous; a clearing pass over all MAX_TOF_BINS*MAX_WAVE_BINS
// entries (4096 by default) zeroes both bin memories before a word is taken.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tof_wavelength_histogram_2d
// Two-dimensional event histogram over time of flight and wavelength.
// ----------------------------------------------------------------------------
module tof_wavelength_histogram_2d #(
   parameter int MAX_TOF_BINS  = 64,
   parameter int MAX_WAVE_BINS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tofwh_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_op,
   input  wire logic                               req_end_of_block,
   input  wire logic [31:0]                        req_flight_time,
   input  wire logic [23:0]                        req_wave_len,
   input  wire logic [31:0]                        req_event_weight,
   input  wire logic [5:0]                         req_read_tof_bin,
   input  wire logic [5:0]                         req_read_wave_bin,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_forward_event,
   output logic                                    rsp_registered,
   output logic [5:0]                              rsp_tof_bin,
   output logic [5:0]                              rsp_wave_bin,
   output logic [31:0]                             rsp_bin_count,
   output logic [47:0]                             rsp_bin_intensity,
   output logic [47:0]                             rsp_total_intensity
);
   import tofwh_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   tofwh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tofwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tofwh_dp #(
      .MAX_TOF_BINS  (MAX_TOF_BINS),
      .MAX_WAVE_BINS (MAX_WAVE_BINS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_op              (req_op),
      .req_end_of_block    (req_end_of_block),
      .req_flight_time     (req_flight_time),
      .req_wave_len        (req_wave_len),
      .req_event_weight    (req_event_weight),
      .req_read_tof_bin    (req_read_tof_bin),
      .req_read_wave_bin   (req_read_wave_bin),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_forward_event   (rsp_forward_event),
      .rsp_registered      (rsp_registered),
      .rsp_tof_bin         (rsp_tof_bin),
      .rsp_wave_bin        (rsp_wave_bin),
      .rsp_bin_count       (rsp_bin_count),
      .rsp_bin_intensity   (rsp_bin_intensity),
      .rsp_total_intensity (rsp_total_intensity)
   );

endmodule
`default_nettype wire

@@ rtl/tofwh_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tofwh_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tofwh_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [tofwh_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic      [31:0]                          csr_prdata,
   output logic                                      csr_pready,
   output tofwh_pkg::cfg_type                        cfg
);
   import tofwh_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;

   assign idx        = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_BINS_TOF:  cfg_in.bins_tof  = csr_pwdata[6:0];
            REG_BINS_WAVE: cfg_in.bins_wave = csr_pwdata[6:0];
            REG_TOF_LOW:   cfg_in.tof_low   = csr_pwdata;
            REG_TOF_HIGH:  cfg_in.tof_high  = csr_pwdata;
            REG_WAVE_LOW:  cfg_in.wave_low  = csr_pwdata[23:0];
            REG_WAVE_HIGH: cfg_in.wave_high = csr_pwdata[23:0];
            REG_USE_WT:    cfg_in.use_weight = csr_pwdata[0];
            REG_EXCLUSIVE: cfg_in.exclusive = csr_pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BINS_TOF:  csr_prdata = {25'd0, cfg_ff.bins_tof};
         REG_BINS_WAVE: csr_prdata = {25'd0, cfg_ff.bins_wave};
         REG_TOF_LOW:   csr_prdata = cfg_ff.tof_low;
         REG_TOF_HIGH:  csr_prdata = cfg_ff.tof_high;
         REG_WAVE_LOW:  csr_prdata = {8'd0, cfg_ff.wave_low};
         REG_WAVE_HIGH: csr_prdata = {8'd0, cfg_ff.wave_high};
         REG_USE_WT:    csr_prdata = {31'd0, cfg_ff.use_weight};
         REG_EXCLUSIVE: csr_prdata = {31'd0, cfg_ff.exclusive};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{bins_tof: 7'd1, bins_wave: 7'd1, tof_low: 32'd0, tof_high: 32'd0,
                     wave_low: 24'd0, wave_high: 24'd0, use_weight: 1'b1,
                     exclusive: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tofwh_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tofwh_ctrl
// Sequencer: clearing pass, then load, divide, memory read and update.
// ----------------------------------------------------------------------------
module tofwh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  tofwh_pkg::sts_type      sts,
   output tofwh_pkg::cmd_type      cmd
);
   import tofwh_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            // The result waits here until the output register is free.
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tofwh_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tofwh_dp
// Datapath: bin dividers, histogram memories, accumulators, result register.
// ----------------------------------------------------------------------------
module tofwh_dp #(
   parameter int MAX_TOF_BINS  = 64,
   parameter int MAX_WAVE_BINS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  tofwh_pkg::cfg_type      cfg,
   input  tofwh_pkg::cmd_type      cmd,
   output tofwh_pkg::sts_type      sts,
   input  wire logic               req_op,
   input  wire logic               req_end_of_block,
   input  wire logic [31:0]        req_flight_time,
   input  wire logic [23:0]        req_wave_len,
   input  wire logic [31:0]        req_event_weight,
   input  wire logic [5:0]         req_read_tof_bin,
   input  wire logic [5:0]         req_read_wave_bin,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_forward_event,
   output logic                    rsp_registered,
   output logic [5:0]              rsp_tof_bin,
   output logic [5:0]              rsp_wave_bin,
   output logic [31:0]             rsp_bin_count,
   output logic [47:0]             rsp_bin_intensity,
   output logic [47:0]             rsp_total_intensity
);
   import tofwh_pkg::*;

   localparam int Depth = MAX_TOF_BINS * MAX_WAVE_BINS;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

   logic [31:0] count_mem  [Depth];
   logic [47:0] weight_mem [Depth];

   logic        op_ff, eob_ff;
   logic [31:0] ft_ff, wt_ff;
   logic [23:0] wl_ff;
   logic [5:0]  rt_ff, rw_ff;
   logic        ok_t_ff, ok_w_ff;
   logic [38:0] rem_t_ff, dsh_t_ff;
   logic [30:0] rem_w_ff, dsh_w_ff;
   logic [6:0]  q_t_ff, q_w_ff;
   logic [2:0]  div_cnt_ff;
   logic [31:0] rd_count_ff;
   logic [47:0] rd_weight_ff;
   logic [47:0] total_ff;
   logic [AW-1:0] clr_addr_ff;
   logic        valid_ff;
   logic        fwd_ff, reg_ff;
   logic [5:0]  tb_ff, wb_ff;
   logic [31:0] cnt_ff;
   logic [47:0] inten_ff, tot_out_ff;

   logic [6:0]  nb_t, nb_w;
   logic [31:0] diff_t;
   logic [23:0] diff_w;
   logic [AW-1:0] ev_addr, rd_addr, acc_addr, wr_addr;
   logic        hit, rd_ok, we;
   logic [31:0] add_val, cnt_new;
   logic [48:0] wsum, tsum;
   logic [47:0] wt_new, tot_new;
   logic [31:0] wr_count;
   logic [47:0] wr_weight;

   assign nb_t = (int'(cfg.bins_tof) > MAX_TOF_BINS) ? 7'(MAX_TOF_BINS) : cfg.bins_tof;
   assign nb_w = (int'(cfg.bins_wave) > MAX_WAVE_BINS) ? 7'(MAX_WAVE_BINS) : cfg.bins_wave;
   assign diff_t = ft_ff - cfg.tof_low;
   assign diff_w = wl_ff - cfg.wave_low;

   assign ev_addr  = AW'(32'(q_t_ff) * 32'(MAX_WAVE_BINS) + 32'(q_w_ff));
   assign rd_addr  = AW'(32'(rt_ff) * 32'(MAX_WAVE_BINS) + 32'(rw_ff));
   assign acc_addr = op_ff ? rd_addr : ev_addr;
   assign rd_ok    = (int'(rt_ff) < MAX_TOF_BINS) && (int'(rw_ff) < MAX_WAVE_BINS);
   assign hit      = !op_ff && !eob_ff && ok_t_ff && ok_w_ff;

   assign add_val = cfg.use_weight ? wt_ff : ONE_Q16;
   assign cnt_new = (rd_count_ff == COUNT_MAX) ? COUNT_MAX : rd_count_ff + 32'd1;
   assign wsum    = {1'b0, rd_weight_ff} + {17'd0, add_val};
   assign tsum    = {1'b0, total_ff} + {17'd0, add_val};
   assign wt_new  = wsum[48] ? SUM_MAX : wsum[47:0];
   assign tot_new = tsum[48] ? SUM_MAX : tsum[47:0];

   assign we        = cmd.clr_wr || (cmd.update && hit);
   assign wr_addr   = cmd.clr_wr ? clr_addr_ff : acc_addr;
   assign wr_count  = cmd.clr_wr ? 32'd0 : cnt_new;
   assign wr_weight = cmd.clr_wr ? 48'd0 : wt_new;

   assign sts.div_last = (div_cnt_ff == 3'd0);
   assign sts.clr_last = (32'(clr_addr_ff) == 32'(Depth - 1));
   assign sts.out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (we) begin
         count_mem[wr_addr]  <= wr_count;
         weight_mem[wr_addr] <= wr_weight;
      end
      if (cmd.mem_rd) begin
         rd_count_ff  <= count_mem[acc_addr];
         rd_weight_ff <= weight_mem[acc_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         eob_ff <= req_end_of_block;
         ft_ff  <= req_flight_time;
         wl_ff  <= req_wave_len;
         wt_ff  <= req_event_weight;
         rt_ff  <= req_read_tof_bin;
         rw_ff  <= req_read_wave_bin;
      end
      if (cmd.load) begin
         // Inside the range exactly when low <= x < high, so the quotient
         // stays below the bin count and fits in seven bits.
         ok_t_ff  <= (nb_t != 7'd0) && (cfg.tof_high > cfg.tof_low) &&
                     (ft_ff >= cfg.tof_low) && (ft_ff < cfg.tof_high);
         ok_w_ff  <= (nb_w != 7'd0) && (cfg.wave_high > cfg.wave_low) &&
                     (wl_ff >= cfg.wave_low) && (wl_ff < cfg.wave_high);
         rem_t_ff <= 39'(nb_t) * 39'(diff_t);
         rem_w_ff <= 31'(nb_w) * 31'(diff_w);
         dsh_t_ff <= {1'b0, cfg.tof_high - cfg.tof_low, 6'd0};
         dsh_w_ff <= {1'b0, cfg.wave_high - cfg.wave_low, 6'd0};
         q_t_ff   <= 7'd0;
         q_w_ff   <= 7'd0;
      end else if (cmd.div_step) begin
         if (rem_t_ff >= dsh_t_ff) begin
            rem_t_ff <= rem_t_ff - dsh_t_ff;
            q_t_ff   <= {q_t_ff[5:0], 1'b1};
         end else begin
            q_t_ff   <= {q_t_ff[5:0], 1'b0};
         end
         if (rem_w_ff >= dsh_w_ff) begin
            rem_w_ff <= rem_w_ff - dsh_w_ff;
            q_w_ff   <= {q_w_ff[5:0], 1'b1};
         end else begin
            q_w_ff   <= {q_w_ff[5:0], 1'b0};
         end
         dsh_t_ff <= dsh_t_ff >> 1;
         dsh_w_ff <= dsh_w_ff >> 1;
      end
      if (cmd.update) begin
         fwd_ff     <= !op_ff && (eob_ff || !cfg.exclusive || hit);
         reg_ff     <= hit;
         tb_ff      <= op_ff ? rt_ff : (hit ? q_t_ff[5:0] : 6'd0);
         wb_ff      <= op_ff ? rw_ff : (hit ? q_w_ff[5:0] : 6'd0);
         cnt_ff     <= (op_ff && rd_ok) ? rd_count_ff : 32'd0;
         inten_ff   <= (op_ff && rd_ok) ? rd_weight_ff : 48'd0;
         tot_out_ff <= hit ? tot_new : total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff  <= '0;
         total_ff    <= '0;
         clr_addr_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (cmd.load) begin
            div_cnt_ff <= DIV_STEPS_LAST;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff - 3'd1;
         end
         if (cmd.clr_wr) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (cmd.update && hit) total_ff <= tot_new;
         if (cmd.update) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_forward_event   = fwd_ff;
   assign rsp_registered      = reg_ff;
   assign rsp_tof_bin         = tb_ff;
   assign rsp_wave_bin        = wb_ff;
   assign rsp_bin_count       = cnt_ff;
   assign rsp_bin_intensity   = inten_ff;
   assign rsp_total_intensity = tot_out_ff;

endmodule
`default_nettype wire

@@ rtl/tofwh_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tofwh_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module tofwh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_forward_event,
   input wire logic        rsp_registered,
   input wire logic [31:0] rsp_bin_count,
   input wire logic [47:0] rsp_bin_intensity
);

   // A result word stays offered until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An event that landed in the histogram is always passed on.
   a_reg_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_registered |-> rsp_forward_event)
      else $error("registered event not forwarded");

   // Forwarded words come from events, which carry no bin readout.
   a_fwd_noread: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward_event |-> rsp_bin_count == 32'd0 &&
                                        rsp_bin_intensity == 48'd0)
      else $error("bin readout on an event word");

endmodule

bind tof_wavelength_histogram_2d tofwh_checker u_tofwh_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_forward_event (rsp_forward_event),
   .rsp_registered    (rsp_registered),
   .rsp_bin_count     (rsp_bin_count),
   .rsp_bin_intensity (rsp_bin_intensity)
);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time of flight / wavelength histogram. Events
// and bin reads are driven with random idling and a long output hold-off; a
// behavioral model of the bin stores predicts every result word.
// ----------------------------------------------------------------------------
module testbench;
   import tofwh_pkg::*;

   localparam int NT = 64;
   localparam int NW = 64;

   typedef struct packed {
      logic        op;
      logic        eob;
      logic [31:0] tof;
      logic [23:0] wl;
      logic [31:0] wt;
      logic [5:0]  rt;
      logic [5:0]  rw;
   } event_word;

   typedef struct packed {
      logic        fwd;
      logic        reg_hit;
      logic [5:0]  tb;
      logic [5:0]  wb;
      logic [31:0] cnt;
      logic [47:0] inten;
      logic [47:0] total;
   } bin_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   logic req_valid = 1'b0, req_stall;
   event_word drv = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   bin_result got;

   // Shadow of the configuration and the bin memories.
   logic [6:0]  m_bins_t, m_bins_w;
   logic [31:0] m_tof_lo, m_tof_hi;
   logic [23:0] m_wl_lo, m_wl_hi;
   logic        m_use_wt, m_excl;
   logic [31:0] m_count [NT*NW];
   logic [47:0] m_sum [NT*NW];
   logic [47:0] m_total;

   event_word pending_events[$];
   bin_result expected_results[$];
   int errors = 0;
   int n_events = 0, n_reads = 0, n_hits = 0;
   bit hold_rsp = 1'b0;
   bit calm = 1'b0;

   tof_wavelength_histogram_2d u_dut (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready,
      .req_valid, .req_stall,
      .req_op(drv.op), .req_end_of_block(drv.eob), .req_flight_time(drv.tof),
      .req_wave_len(drv.wl), .req_event_weight(drv.wt),
      .req_read_tof_bin(drv.rt), .req_read_wave_bin(drv.rw),
      .rsp_valid, .rsp_stall,
      .rsp_forward_event(got.fwd), .rsp_registered(got.reg_hit),
      .rsp_tof_bin(got.tb), .rsp_wave_bin(got.wb), .rsp_bin_count(got.cnt),
      .rsp_bin_intensity(got.inten), .rsp_total_intensity(got.total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? SUM_MAX : s[47:0];
   endfunction

   function automatic bit place_on_axis(logic [31:0] x, logic [31:0] lo,
                                        logic [31:0] hi, logic [6:0] nb_in,
                                        int maxb, output logic [5:0] idx);
      logic [63:0] nb, q;
      nb = (nb_in > maxb) ? 64'(maxb) : 64'(nb_in);
      idx = '0;
      if (nb == 0 || hi <= lo || x < lo) return 1'b0;
      q = (nb * 64'(x - lo)) / 64'(hi - lo);
      if (q >= nb) return 1'b0;
      idx = q[5:0];
      return 1'b1;
   endfunction

   function automatic bin_result predict_histogram(event_word e);
      bin_result r;
      logic [5:0] it, iw;
      bit ok_t, ok_w;
      int a;
      logic [47:0] add;
      r = '0;
      if (e.op) begin
         r.tb = e.rt;
         r.wb = e.rw;
         a = e.rt * NW + e.rw;
         r.cnt = m_count[a];
         r.inten = m_sum[a];
      end else if (e.eob) begin
         r.fwd = 1'b1;
      end else begin
         ok_t = place_on_axis(e.tof, m_tof_lo, m_tof_hi, m_bins_t, NT, it);
         ok_w = place_on_axis({8'd0, e.wl}, {8'd0, m_wl_lo}, {8'd0, m_wl_hi},
                              m_bins_w, NW, iw);
         if (ok_t && ok_w) begin
            add = m_use_wt ? {16'd0, e.wt} : {16'd0, ONE_Q16};
            a = it * NW + iw;
            if (m_count[a] != COUNT_MAX) m_count[a] = m_count[a] + 1;
            m_sum[a] = sat48(m_sum[a], add);
            m_total = sat48(m_total, add);
            r.reg_hit = 1'b1;
            r.tb = it;
            r.wb = iw;
         end
         r.fwd = !m_excl || r.reg_hit;
      end
      r.total = m_total;
      return r;
   endfunction

   // Driver: offers the next pending word, idling at random outside calm spells.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_histogram(drv));
            if (drv.op) n_reads++; else n_events++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_events.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
               req_valid <= 1'b1;
               drv <= pending_events.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result word against the oldest prediction.
   always @(posedge clock) begin
      bin_result e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (got.reg_hit) n_hits++;
               if (got.fwd !== e.fwd) begin
                  $error("forward_event exp %0h got %0h", e.fwd, got.fwd); errors++;
               end
               if (got.reg_hit !== e.reg_hit) begin
                  $error("registered exp %0h got %0h", e.reg_hit, got.reg_hit); errors++;
               end
               if (got.tb !== e.tb) begin
                  $error("tof_bin exp %0h got %0h", e.tb, got.tb); errors++;
               end
               if (got.wb !== e.wb) begin
                  $error("wave_bin exp %0h got %0h", e.wb, got.wb); errors++;
               end
               if (got.cnt !== e.cnt) begin
                  $error("bin_count exp %0h got %0h", e.cnt, got.cnt); errors++;
               end
               if (got.inten !== e.inten) begin
                  $error("bin_intensity exp %0h got %0h", e.inten, got.inten); errors++;
               end
               if (got.total !== e.total) begin
                  $error("total_intensity exp %0h got %0h", e.total, got.total);
                  errors++;
               end
            end
         end
         rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < 29);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CsrAddrWidth'(4 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_BINS_TOF:  m_bins_t = val[6:0];
         REG_BINS_WAVE: m_bins_w = val[6:0];
         REG_TOF_LOW:   m_tof_lo = val;
         REG_TOF_HIGH:  m_tof_hi = val;
         REG_WAVE_LOW:  m_wl_lo = val[23:0];
         REG_WAVE_HIGH: m_wl_hi = val[23:0];
         REG_USE_WT:    m_use_wt = val[0];
         default:       m_excl = val[0];
      endcase
   endtask

   task automatic setup(logic [6:0] bt, logic [6:0] bw, logic [31:0] tl,
                        logic [31:0] th, logic [23:0] wl, logic [23:0] wh,
                        logic uw, logic ex);
      csr_write(REG_BINS_TOF, 32'(bt));
      csr_write(REG_BINS_WAVE, 32'(bw));
      csr_write(REG_TOF_LOW, tl);
      csr_write(REG_TOF_HIGH, th);
      csr_write(REG_WAVE_LOW, 32'(wl));
      csr_write(REG_WAVE_HIGH, 32'(wh));
      csr_write(REG_USE_WT, 32'(uw));
      csr_write(REG_EXCLUSIVE, 32'(ex));
   endtask

   task automatic drain;
      while (pending_events.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic event_word bin_event(logic eob, logic [31:0] t,
                                          logic [23:0] w, logic [31:0] wt);
      event_word e;
      e = '0;
      e.eob = eob; e.tof = t; e.wl = w; e.wt = wt;
      e.rt = 6'($urandom); e.rw = 6'($urandom);
      return e;
   endfunction

   function automatic event_word read_event(logic [5:0] rt, logic [5:0] rw);
      event_word e;
      e = '0;
      e.op = 1'b1; e.eob = 1'($urandom); e.rt = rt; e.rw = rw;
      e.tof = $urandom; e.wl = 24'($urandom); e.wt = $urandom;
      return e;
   endfunction

   // Random word: mostly events near the configured window, some reads, some noise.
   function automatic event_word random_word;
      int k;
      logic [31:0] span_t;
      logic [23:0] span_w;
      k = $urandom_range(99);
      span_t = (m_tof_hi > m_tof_lo) ? m_tof_hi - m_tof_lo : 32'd1;
      span_w = (m_wl_hi > m_wl_lo) ? m_wl_hi - m_wl_lo : 24'd1;
      if (k < 20) return read_event(6'($urandom), 6'($urandom));
      if (k < 25) return bin_event(1'b1, $urandom, 24'($urandom), $urandom);
      if (k < 35) return bin_event(1'b0, $urandom, 24'($urandom), $urandom);
      return bin_event(1'b0, m_tof_lo + $urandom_range(span_t - 1),
                       m_wl_lo + 24'($urandom_range(32'(span_w) - 1)),
                       (k < 40) ? $urandom : $urandom_range(32'h0004_0000));
   endfunction

   initial begin
      int a;
      m_bins_t = 7'd1; m_bins_w = 7'd1; m_tof_lo = '0; m_tof_hi = '0;
      m_wl_lo = '0; m_wl_hi = '0; m_use_wt = 1'b1; m_excl = 1'b0; m_total = '0;
      for (a = 0; a < NT*NW; a++) begin
         m_count[a] = '0;
         m_sum[a] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Reset configuration: empty axes, so nothing registers.
      pending_events.push_back(bin_event(1'b0, 32'd0, 24'd0, 32'hFFFF_FFFF));
      pending_events.push_back(bin_event(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd5));
      pending_events.push_back(read_event(6'd0, 6'd0));
      drain();

      setup(7'd8, 7'd4, 32'h0001_0000, 32'h0009_0000, 24'h01_0000, 24'h05_0000,
            1'b1, 1'b1);
      pending_events.push_back(bin_event(1'b0, 32'h0001_0000, 24'h01_0000, 32'd3));
      pending_events.push_back(bin_event(1'b0, 32'h0008_FFFF, 24'h04_FFFF,
                                         32'hFFFF_FFFF));
      pending_events.push_back(bin_event(1'b0, 32'h0009_0000, 24'h02_0000, 32'd7));
      pending_events.push_back(bin_event(1'b0, 32'h0000_FFFF, 24'h02_0000, 32'd7));
      pending_events.push_back(bin_event(1'b0, 32'h0002_0000, 24'h05_0000, 32'd7));
      pending_events.push_back(bin_event(1'b1, 32'h0002_0000, 24'h02_0000, 32'd7));
      pending_events.push_back(read_event(6'd0, 6'd0));
      pending_events.push_back(read_event(6'd7, 6'd3));
      pending_events.push_back(read_event(6'd63, 6'd63));
      drain();

      // Bins zero, and an inverted axis.
      setup(7'd0, 7'd4, 32'h0001_0000, 32'h0009_0000, 24'h05_0000, 24'h01_0000,
            1'b0, 1'b1);
      pending_events.push_back(bin_event(1'b0, 32'h0002_0000, 24'h02_0000, 32'd9));
      drain();
      // Oversized bin registers, full ranges, unit weights.
      setup(7'd127, 7'd100, 32'd0, 32'hFFFF_FFFF, 24'd0, 24'hFF_FFFF, 1'b0, 1'b0);
      pending_events.push_back(bin_event(1'b0, 32'hFFFF_FFFE, 24'hFF_FFFE, 32'd1));
      pending_events.push_back(bin_event(1'b0, 32'd0, 24'd0, 32'd1));
      pending_events.push_back(read_event(6'd63, 6'd63));
      drain();

      // Large sums: one tiny bin hammered with maximal weights, short of saturation.
      setup(7'd1, 7'd1, 32'd0, 32'd16, 24'd0, 24'd16, 1'b1, 1'b0);
      calm = 1'b1;
      repeat (40)
         pending_events.push_back(bin_event(1'b0, 32'($urandom_range(15)),
                                            24'($urandom_range(15)), 32'hFFFF_FFFF));
      pending_events.push_back(read_event(6'd0, 6'd0));
      drain();
      calm = 1'b0;

      // Random phases over several settings, including a long output hold-off.
      for (int ph = 0; ph < 6; ph++) begin
         logic [31:0] tl;
         logic [23:0] wl;
         tl = $urandom_range(32'h0100_0000);
         wl = 24'($urandom_range(24'h10_0000));
         setup(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), tl,
               tl + $urandom_range(32'h0010_0000, 32'h0100_0000), wl,
               wl + 24'($urandom_range(32'h01_0000, 32'h40_0000)),
               1'($urandom), 1'($urandom));
         calm = (ph == 2);
         repeat (120) pending_events.push_back(random_word());
         if (ph == 4) begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         drain();
      end
      calm = 1'b0;
      $display("Covered %0d binning words and %0d bin reads, %0d events registered.",
               n_events, n_reads, n_hits);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
